### sv/assert_macros.svh
// assertion macros used by the checker file hpk_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent must hold on the same edge
`define HPK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// antecedent holds, consequent must hold on the next edge
`define HPK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### sv/hpk_pkg.sv
// ----------------------------------------------------------------------------
// hpk_pkg
// Types, codes and arithmetic helpers of the grey to 1bpp halftone packer.
// ----------------------------------------------------------------------------
package hpk_pkg;

	typedef logic signed [9:0] err_t;

	typedef struct packed {
		logic [7:0] grey;
		logic       page_start;
	} pix_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       row_last;
	} pbyte_t;

	// operands of the per-pixel decision
	typedef struct packed {
		logic [7:0] grey;
		logic [2:0] phase;
		logic [2:0] col;
		logic       last;
		err_t       carry;
		err_t       store;
		err_t       pend0;
		err_t       pend1;
	} pxin_t;

	typedef struct packed {
		logic black;
		err_t carry_nx;
		err_t below_left;
		err_t pend0_nx;
		err_t pend1_nx;
	} pxres_t;

	localparam logic [1:0] MODE_THRESH  = 2'd0;
	localparam logic [1:0] MODE_SCREEN  = 2'd1;
	localparam logic [1:0] MODE_DIFFUSE = 2'd2;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	localparam logic [1:0]  MODE_RESET  = MODE_THRESH;
	localparam logic [11:0] WIDTH_RESET = 12'd1248;
	localparam logic [7:0]  BYTE_WHITE  = 8'hFF;
	localparam logic [7:0]  INK_MIN     = 8'd128;
	localparam err_t        VAL_MIN     = 10'sd128;

	localparam logic [5:0] SCREEN [64] = '{
		6'd24, 6'd10, 6'd12, 6'd26, 6'd35, 6'd47, 6'd49, 6'd37,
		6'd8,  6'd0,  6'd2,  6'd14, 6'd45, 6'd59, 6'd61, 6'd51,
		6'd22, 6'd6,  6'd4,  6'd16, 6'd43, 6'd57, 6'd63, 6'd53,
		6'd30, 6'd20, 6'd18, 6'd28, 6'd33, 6'd41, 6'd55, 6'd39,
		6'd34, 6'd46, 6'd48, 6'd36, 6'd25, 6'd11, 6'd13, 6'd27,
		6'd44, 6'd58, 6'd60, 6'd50, 6'd9,  6'd1,  6'd3,  6'd15,
		6'd42, 6'd56, 6'd62, 6'd52, 6'd23, 6'd7,  6'd5,  6'd17,
		6'd32, 6'd40, 6'd54, 6'd38, 6'd31, 6'd21, 6'd19, 6'd29
	};

	// entry * 255 / 64
	function automatic logic [7:0] screen_thr(input logic [2:0] row, input logic [2:0] col);
		logic [5:0]  e;
		logic [13:0] p;
		e = SCREEN[{row, col}];
		p = {e, 8'd0} - {8'd0, e};
		return p[13:6];
	endfunction

	function automatic logic signed [13:0] ext14(input err_t e);
		return {{4{e[9]}}, e};
	endfunction

	function automatic err_t sat10(input logic signed [13:0] v);
		err_t r;
		if (v > 14'sd511) begin
			r = 10'sd511;
		end else if (v < -14'sd512) begin
			r = -10'sd512;
		end else begin
			r = v[9:0];
		end
		return r;
	endfunction

	// divide by 16, rounding toward zero
	function automatic logic signed [13:0] div16(input logic signed [13:0] p);
		logic signed [13:0] q;
		if (p < 14'sd0) begin
			q = (p + 14'sd15) >>> 4;
		end else begin
			q = p >>> 4;
		end
		return q;
	endfunction

endpackage

### sv/hpk_ram.sv
// ----------------------------------------------------------------------------
// hpk_ram
// One bank of the error line store: one write and one registered read port.
// ----------------------------------------------------------------------------
module hpk_ram import hpk_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  err_t                     wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output err_t                     rdata
);

	err_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/hpk_pixel.sv
// ----------------------------------------------------------------------------
// hpk_pixel
// Per-pixel dot decision and error shares for all three halftone modes.
// ----------------------------------------------------------------------------
module hpk_pixel import hpk_pkg::*; (
	input  logic [1:0] mode,
	input  pxin_t      px,
	output pxres_t     res
);

	logic [7:0]         ink;
	logic [7:0]         thr;
	logic signed [13:0] sum;
	logic signed [13:0] errv;
	err_t               val;
	logic               black;

	assign ink = ~px.grey;
	assign thr = screen_thr(px.phase, px.col);
	assign sum = $signed({6'd0, ink}) + ext14(px.carry) + ext14(px.store);
	assign val = sat10(sum);

	always_comb begin
		unique case (mode)
			MODE_SCREEN:  black = ink > thr;
			MODE_DIFFUSE: black = val >= VAL_MIN;
			default:      black = ink >= INK_MIN;
		endcase
	end

	// other modes spread a zero error
	assign errv = (mode == MODE_DIFFUSE) ? ext14(val) - (black ? 14'sd255 : 14'sd0) : 14'sd0;

	always_comb begin
		res.black      = black;
		res.carry_nx   = px.last ? '0 : sat10(div16(errv * 14'sd7));
		res.below_left = sat10(ext14(px.pend0) + div16(errv * 14'sd3));
		res.pend0_nx   = sat10(ext14(px.pend1) + div16(errv * 14'sd5));
		res.pend1_nx   = sat10(div16(errv));
	end

endmodule

### sv/grey_to_1bpp_halftone_packer.sv
// ----------------------------------------------------------------------------
// grey_to_1bpp_halftone_packer
// A byte is packed in stage 1, then shown from the output register.
// Throughput: one pixel per clock; a pixel waits only while a finished byte
// sits unread in the output register and its own byte is also due.
// Reset clears position, errors and registers; the line store is not cleared.
// ----------------------------------------------------------------------------
module grey_to_1bpp_halftone_packer import hpk_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pix_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pbyte_t      out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int BDEPTH = (MAX_WIDTH + 1) / 2;
	localparam int BW     = $clog2(BDEPTH);
	localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

	// configuration
	logic [1:0]  mode_q;
	logic [11:0] width_q;

	// position state
	logic [AW-1:0] column_q;
	logic [2:0]    phase_q;
	logic          first_q;

	// error and byte state
	err_t       carry_q;
	err_t       pend0_q;
	err_t       pend1_q;
	logic [7:0] acc_q;

	// stage 1: line store data is back
	logic          valid_s1;
	logic [7:0]    grey_s1;
	logic          ps_s1;
	logic [AW-1:0] x_s1;
	logic          last_s1;
	logic [2:0]    phase_s1;
	logic          first_s1;
	logic          fwd_s1;
	err_t          fwdd_s1;

	logic   out_valid_q;
	pbyte_t out_q;

	logic          accept;
	logic          fire;
	logic          stall;
	logic          emit;
	logic [AW-1:0] x_n;
	logic [2:0]    phase_n;
	logic          first_n;
	logic [12:0]   lw;
	logic [12:0]   wc;
	logic          last_n;

	err_t   rd_even;
	err_t   rd_odd;
	err_t   store;
	pxin_t  px;
	pxres_t res;
	logic [7:0] acc_in;
	logic [7:0] acc_new;

	logic          we_a;
	logic          we_b;
	logic [AW-1:0] addr_a;
	logic          hit_a;
	logic          hit_b;
	logic          we_even;
	logic          we_odd;
	logic [BW-1:0] wa_even;
	logic [BW-1:0] wa_odd;
	err_t          wd_even;
	err_t          wd_odd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			width_q <= WIDTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[1:0];
				REG_WIDTH: width_q <= cfg_data;
			endcase
		end
	end

	// ---------------- accept side: position and line store read ----------------
	assign accept = in_valid && in_ready;
	assign x_n     = in_data.page_start ? '0 : column_q;
	assign phase_n = in_data.page_start ? 3'd0 : phase_q;
	assign first_n = in_data.page_start ? 1'b1 : first_q;

	assign lw = {1'b0, width_q};
	always_comb begin
		if (lw == 13'd0) begin
			wc = 13'd1;
		end else if (lw > MAXW) begin
			wc = MAXW;
		end else begin
			wc = lw;
		end
	end
	assign last_n = (13'(x_n) + 13'd1) >= wc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			phase_q  <= 3'd0;
			first_q  <= 1'b1;
		end else if (accept) begin
			column_q <= last_n ? '0 : x_n + 1'b1;
			phase_q  <= last_n ? phase_n + 3'd1 : phase_n;
			first_q  <= last_n ? 1'b0 : first_n;
		end
	end

	// writes by the stage 1 pixel land in the same cycle as the next read
	assign hit_a = we_a && (addr_a == x_n);
	assign hit_b = we_b && (x_s1 == x_n);

	always_ff @(posedge clk) begin
		if (accept) begin
			grey_s1  <= in_data.grey;
			ps_s1    <= in_data.page_start;
			x_s1     <= x_n;
			last_s1  <= last_n;
			phase_s1 <= phase_n;
			first_s1 <= first_n;
			fwd_s1   <= hit_a || hit_b;
			fwdd_s1  <= hit_a ? res.below_left : res.pend0_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// ---------------- stage 1: decide, diffuse, pack ----------------
	assign store = fwd_s1 ? fwdd_s1 : (x_s1[0] ? rd_odd : rd_even);

	always_comb begin
		px.grey  = grey_s1;
		px.phase = phase_s1;
		px.col   = x_s1[2:0];
		px.last  = last_s1;
		px.carry = ps_s1 ? '0 : carry_q;
		px.store = first_s1 ? '0 : store;
		px.pend0 = ps_s1 ? '0 : pend0_q;
		px.pend1 = ps_s1 ? '0 : pend1_q;
	end

	hpk_pixel u_pixel (
		.mode (mode_q),
		.px   (px),
		.res  (res)
	);

	assign acc_in  = ps_s1 ? BYTE_WHITE : acc_q;
	assign acc_new = res.black ? (acc_in & ~(8'h80 >> x_s1[2:0])) : acc_in;
	assign emit    = (x_s1[2:0] == 3'd7) || last_s1;

	assign stall    = valid_s1 && emit && out_valid_q && !out_ready;
	assign fire     = valid_s1 && !stall;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			pend0_q <= '0;
			pend1_q <= '0;
			acc_q   <= BYTE_WHITE;
		end else if (fire) begin
			carry_q <= res.carry_nx;
			pend0_q <= last_s1 ? '0 : res.pend0_nx;
			pend1_q <= last_s1 ? '0 : res.pend1_nx;
			acc_q   <= emit ? BYTE_WHITE : acc_new;
		end
	end

	// below-left share goes to x-1, and at row end the pending sum goes to x
	assign we_a   = fire && (x_s1 != '0);
	assign we_b   = fire && last_s1;
	assign addr_a = x_s1 - 1'b1;

	always_comb begin
		if (x_s1[0]) begin
			we_even = we_a;
			wa_even = BW'(addr_a >> 1);
			wd_even = res.below_left;
			we_odd  = we_b;
			wa_odd  = BW'(x_s1 >> 1);
			wd_odd  = res.pend0_nx;
		end else begin
			we_even = we_b;
			wa_even = BW'(x_s1 >> 1);
			wd_even = res.pend0_nx;
			we_odd  = we_a;
			wa_odd  = BW'(addr_a >> 1);
			wd_odd  = res.below_left;
		end
	end

	hpk_ram #(.DEPTH(BDEPTH)) u_bank_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (wa_even),
		.wdata (wd_even),
		.re    (accept),
		.raddr (BW'(x_n >> 1)),
		.rdata (rd_even)
	);

	hpk_ram #(.DEPTH(BDEPTH)) u_bank_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (wa_odd),
		.wdata (wd_odd),
		.re    (accept),
		.raddr (BW'(x_n >> 1)),
		.rdata (rd_odd)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_q.packed_byte <= acc_new;
			out_q.row_last    <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### sv/hpk_checker.sv
// ----------------------------------------------------------------------------
// hpk_checker
// Port-level checks of the halftone packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpk_checker import hpk_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input pbyte_t out_data
);

	// a byte waiting for the sink holds still
	`HPK_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// with the output register empty nothing can block the input
	`HPK_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready)

	// a fresh byte comes from a pixel transfer through stage 1 and the output register
	`HPK_ASSERT_IMP(a_out_origin, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind grey_to_1bpp_halftone_packer hpk_checker u_hpk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives grey pixels into the halftone packer and checks every packed byte
// against an in-bench dither and packing predictor or a table byte. A short
// directed table comes first, then random phases varying mode, row width, tone.
// ----------------------------------------------------------------------------
module testbench;
	import hpk_pkg::*;

	localparam int MAX_W = 2048;
	localparam int RANDOM_PIXELS = 1750;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD = 400;
	// unused mode code, behaves as plain threshold
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int DOT_SCREEN [64] = '{
		24, 10, 12, 26, 35, 47, 49, 37,
		 8,  0,  2, 14, 45, 59, 61, 51,
		22,  6,  4, 16, 43, 57, 63, 53,
		30, 20, 18, 28, 33, 41, 55, 39,
		34, 46, 48, 36, 25, 11, 13, 27,
		44, 58, 60, 50,  9,  1,  3, 15,
		42, 56, 62, 52, 23,  7,  5, 17,
		32, 40, 54, 38, 31, 21, 19, 29
	};

	typedef enum logic [1:0] {ROW_REG, ROW_PIX, ROW_KNOWN} row_kind_e;
	typedef enum int {TONE_ANY, TONE_EDGES, TONE_FLAT, TONE_DARK, TONE_LIGHT} tone_e;

	typedef struct packed {
		row_kind_e  kind;
		logic       idx;
		logic [11:0] val;
		logic [7:0] grey;
		logic       ps;
		logic [7:0] byte_exp;
		logic       last_exp;
	} plan_row_t;

	localparam plan_row_t PLAN [25] = '{
		'{ROW_REG,   REG_WIDTH, 12'd1,            8'd0,   1'b0, 8'h00, 1'b0},
		'{ROW_KNOWN, REG_MODE,  12'd0,            8'd0,   1'b1, 8'h7F, 1'b1},
		'{ROW_KNOWN, REG_MODE,  12'd0,            8'd255, 1'b0, 8'hFF, 1'b1},
		'{ROW_KNOWN, REG_MODE,  12'd0,            8'd128, 1'b0, 8'hFF, 1'b1},
		'{ROW_KNOWN, REG_MODE,  12'd0,            8'd127, 1'b0, 8'h7F, 1'b1},
		'{ROW_REG,   REG_WIDTH, 12'd0,            8'd0,   1'b0, 8'h00, 1'b0},
		'{ROW_KNOWN, REG_MODE,  12'd0,            8'd0,   1'b0, 8'h7F, 1'b1},
		'{ROW_REG,   REG_MODE,  12'(MODE_SPARE),  8'd0,   1'b0, 8'h00, 1'b0},
		'{ROW_KNOWN, REG_MODE,  12'd0,            8'd128, 1'b0, 8'hFF, 1'b1},
		'{ROW_KNOWN, REG_MODE,  12'd0,            8'd127, 1'b0, 8'h7F, 1'b1},
		'{ROW_REG,   REG_MODE,  12'(MODE_SCREEN), 8'd0,   1'b0, 8'h00, 1'b0},
		'{ROW_REG,   REG_WIDTH, 12'd2,            8'd0,   1'b0, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd128, 1'b1, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd128, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd255, 1'b0, 8'h00, 1'b0},
		// screen entry zero: no ink never prints
		'{ROW_KNOWN, REG_MODE,  12'd0,            8'd255, 1'b0, 8'hFF, 1'b1},
		'{ROW_REG,   REG_MODE,  12'(MODE_DIFFUSE), 8'd0,  1'b0, 8'h00, 1'b0},
		'{ROW_REG,   REG_WIDTH, 12'd3,            8'd0,   1'b0, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd0,   1'b1, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd255, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd0,   1'b0, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd128, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd64,  1'b0, 8'h00, 1'b0},
		// new page in the middle of a row
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd10,  1'b1, 8'h00, 1'b0},
		'{ROW_PIX,   REG_MODE,  12'd0,            8'd250, 1'b0, 8'h00, 1'b0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	pix_t        in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	pbyte_t      out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_MODE;
	logic [11:0] cfg_data = '0;

	grey_to_1bpp_halftone_packer #(
		.MAX_WIDTH(MAX_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic [1:0]  cfg_mode = MODE_RESET;
	logic [11:0] cfg_width = WIDTH_RESET;
	int          col_pos;
	int          row_phase;
	bit          on_first_row;
	logic [7:0]  dots;
	int          carry_err;
	int          below_pend [2];
	int          line_err [MAX_W];
	bit          line_seen [MAX_W];

	pbyte_t bytes_due [$];

	int send_idle_pct = 19;
	int recv_idle_pct = 87;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int pixels_sent = 0;
	int bytes_checked = 0;
	int mismatches = 0;
	int reg_writes = 0;
	logic [7:0] run_grey = 8'd128;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int clip10(input int v);
		if (v > 511) return 511;
		if (v < -512) return -512;
		return v;
	endfunction

	task automatic clear_page();
		col_pos = 0;
		row_phase = 0;
		on_first_row = 1'b1;
		dots = 8'hFF;
		carry_err = 0;
		below_pend[0] = 0;
		below_pend[1] = 0;
	endtask

	// halftone one pixel, update the error pipeline and the byte being packed
	task automatic dither_pixel(input pix_t px, output bit got, output pbyte_t res);
		int w, x, ink, err, val, thr;
		bit black, row_end;
		if (px.page_start) clear_page();
		w = cfg_width;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		x = col_pos;
		row_end = (x + 1 >= w);
		ink = 255 - int'(px.grey);
		err = 0;
		unique case (cfg_mode)
			MODE_SCREEN: begin
				thr = DOT_SCREEN[row_phase * 8 + x % 8] * 255 / 64;
				black = ink > thr;
			end
			MODE_DIFFUSE: begin
				val = ink + carry_err;
				if (!on_first_row) val += line_err[x];
				val = clip10(val);
				black = val >= 128;
				err = val - (black ? 255 : 0);
			end
			default: begin
				black = ink >= 128;
			end
		endcase
		carry_err = row_end ? 0 : clip10(err * 7 / 16);
		if (x > 0) begin
			line_err[x - 1] = clip10(below_pend[0] + err * 3 / 16);
			line_seen[x - 1] = 1'b1;
		end
		below_pend[0] = clip10(below_pend[1] + err * 5 / 16);
		below_pend[1] = clip10(err / 16);
		if (row_end) begin
			line_err[x] = below_pend[0];
			line_seen[x] = 1'b1;
			below_pend[0] = 0;
			below_pend[1] = 0;
		end
		if (black) dots[7 - x % 8] = 1'b0;
		got = (x % 8 == 7) || row_end;
		res = '0;
		if (got) begin
			res.packed_byte = dots;
			res.row_last = row_end;
			dots = 8'hFF;
		end
		if (row_end) begin
			col_pos = 0;
			row_phase = (row_phase + 1) % 8;
			on_first_row = 1'b0;
		end else begin
			col_pos = x + 1;
		end
	endtask

	// valid stays up across back-to-back transfers, dropped only for an idle gap or a settle
	task automatic send_pixel(input pix_t px, input bit known, input pbyte_t known_res);
		bit got;
		pbyte_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		dither_pixel(px, got, res);
		if (got) bytes_due.push_back(known ? known_res : res);
	endtask

	task automatic write_reg(input logic idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		if (idx == REG_MODE) cfg_mode = val[1:0];
		else cfg_width = val;
	endtask

	// drain everything, then give a pixel with no byte time to retire
	task automatic settle();
		in_valid <= 1'b0;
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_grey(input tone_e tone);
		unique case (tone)
			TONE_ANY: return 8'($urandom_range(255));
			TONE_EDGES: begin
				unique case ($urandom_range(3))
					0: return 8'd0;
					1: return 8'd255;
					2: return 8'd127;
					default: return 8'd128;
				endcase
			end
			TONE_FLAT: begin
				if ($urandom_range(7) == 0) run_grey = 8'($urandom_range(255));
				return run_grey;
			end
			TONE_DARK: return 8'($urandom_range(40));
			default: return 8'($urandom_range(255, 215));
		endcase
	endfunction

	function automatic logic [11:0] pick_width();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 12'($urandom_range(16, 1));
		if (r < 80) return 12'($urandom_range(72, 17));
		if (r < 86) return 12'd0;
		if (r < 93) begin
			unique case ($urandom_range(3))
				0: return 12'd8;
				1: return 12'd9;
				2: return 12'd16;
				default: return 12'(MAX_W);
			endcase
		end
		return 12'($urandom_range(4095, MAX_W + 1));
	endfunction

	// receiver: random stalls, or one long hold when asked
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : byte_check
		pbyte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (bytes_due.size() == 0) begin
				$error("unexpected byte transfer: %02h row_last %0b",
					out_data.packed_byte, out_data.row_last);
				mismatches++;
			end else begin
				want = bytes_due.pop_front();
				bytes_checked++;
				if (out_data.packed_byte !== want.packed_byte) begin
					$error("packed_byte: expected %02h, got %02h",
						want.packed_byte, out_data.packed_byte);
					mismatches++;
				end
				if (out_data.row_last !== want.row_last) begin
					$error("row_last: expected %0b, got %0b",
						want.row_last, out_data.row_last);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t r;
		pix_t px;
		int rand_pixels, phase_no, n;
		bit new_page;
		tone_e tone;
		clear_page();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			r = PLAN[i];
			if (r.kind == ROW_REG) begin
				settle();
				write_reg(r.idx, r.val);
			end else begin
				cfg_valid <= 1'b0;
				px.grey = r.grey;
				px.page_start = r.ps;
				send_pixel(px, r.kind == ROW_KNOWN, {r.byte_exp, r.last_exp});
			end
		end

		rand_pixels = 0;
		phase_no = 0;
		while (rand_pixels < RANDOM_PIXELS) begin
			settle();
			if ($urandom_range(99) < 60) begin
				write_reg(REG_MODE, ($urandom_range(1) != 0) ? 12'(MODE_DIFFUSE)
					: 12'($urandom_range(3)));
			end
			if (phase_no == 3) begin
				// fill the output side while the receiver holds off
				write_reg(REG_WIDTH, 12'($urandom_range(4, 1)));
				n = 60;
				hold_req = 1'b1;
			end else begin
				if ($urandom_range(99) < 70) write_reg(REG_WIDTH, pick_width());
				n = $urandom_range(90, 8);
			end
			cfg_valid <= 1'b0;
			new_page = ($urandom_range(1) != 0);
			tone = tone_e'($urandom_range(4));
			for (int k = 0; k < n; k++) begin
				if (rand_pixels < RANDOM_PIXELS / 3) begin
					send_idle_pct = 19;
					recv_idle_pct = 87;
				end else if (rand_pixels < 2 * RANDOM_PIXELS / 3) begin
					send_idle_pct = 87;
					recv_idle_pct = 19;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				px.grey = pick_grey(tone);
				px.page_start = (k == 0 && new_page) || ($urandom_range(63) == 0);
				// never let diffusion read a line store entry that was never written
				if (cfg_mode == MODE_DIFFUSE && !px.page_start && !on_first_row &&
						!line_seen[col_pos])
					px.page_start = 1'b1;
				send_pixel(px, 1'b0, '0);
				rand_pixels++;
			end
			phase_no++;
		end

		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d pixels and %0d bytes, %0d register writes, %0d random phases",
			pixels_sent, bytes_checked, reg_writes, phase_no);
		$display("all modes, widths 0 to 4095, page restarts and a long output hold");
		if (mismatches == 0 && bytes_due.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
